@@ design/sql_like_pattern_matcher_macros.svh @@
// Assertion macros shared by the matcher RTL
`ifndef SQL_LIKE_PATTERN_MATCHER_MACROS_SVH
`define SQL_LIKE_PATTERN_MATCHER_MACROS_SVH

`ifndef ASSERT_OFF
`define SLPM_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("slpm assertion failed");
`define SLPM_NEVER(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("slpm forbidden condition seen");
`else
`define SLPM_ASSERT(name, clk, rstn, prop)
`define SLPM_NEVER(name, clk, rstn, cond)
`endif

`endif

@@ design/slpm_pkg.sv @@
package slpm_pkg;

    localparam int SLOT_FW = 4;

    typedef enum logic [1:0] {
        OP_PAT_BYTE = 2'd0,
        OP_PAT_END  = 2'd1,
        OP_SUB_BYTE = 2'd2,
        OP_SUB_END  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        K_LIT = 2'd0,
        K_ONE = 2'd1,
        K_ANY = 2'd2,
        K_SET = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_NORMAL   = 3'd0,
        PH_ESCAPE   = 3'd1,
        PH_OPEN     = 3'd2,
        PH_LEADDASH = 3'd3,
        PH_BODY     = 3'd4,
        PH_RANGE    = 3'd5,
        PH_ERROR    = 3'd6,
        PH_IDLE     = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_SWEEP  = 2'd1,
        ST_MATCH  = 2'd2
    } state_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_EMPTY   = 3'd1,
        ERR_ESCAPE  = 3'd2,
        ERR_BAD_SET = 3'd3,
        ERR_BRACKET = 3'd4,
        ERR_LONG    = 3'd5,
        ERR_NO_PAT  = 3'd6
    } err_t;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] byte_value;
    } in_word_t;

    typedef struct packed {
        logic       result_kind;
        logic       matched;
        logic [2:0] error_code;
    } out_word_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         literal;
        logic [SLOT_FW-1:0] slot;
    } elem_t;

    typedef struct packed {
        logic       init;
        logic       step;
        logic [7:0] byte_value;
    } cell_ctl_t;

    typedef struct packed {
        logic       start;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       val;
    } sweep_req_t;

endpackage

@@ design/slpm_cell.sv @@
module slpm_cell #(
    parameter int SETS  = 8,
    parameter bit FIRST = 1'b0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  slpm_pkg::cell_ctl_t ctl,
    input  logic              we,
    input  slpm_pkg::elem_t   wr_elem,
    input  logic              live,
    input  logic              is_end,
    input  logic [SETS-1:0]   row,
    input  logic              clo_in,
    input  logic              adv_in,
    output logic              clo_out,
    output logic              adv_out,
    output logic              act_c
);
    import slpm_pkg::*;

    localparam int SLOT_W = (SETS > 1) ? $clog2(SETS) : 1;

    elem_t elem_reg;
    logic  act_reg;
    logic  act_next;
    logic  any;
    logic  hit;

    // hold the element written by the compiler
    always_ff @(posedge aclk) begin
        if (we) begin
            elem_reg <= wr_elem;
        end
    end

    // close over a preceding run wildcard
    assign act_c = act_reg | clo_in;
    assign any   = live & (elem_reg.kind == K_ANY);

    always_comb begin
        case (elem_reg.kind)
            K_LIT:   hit = (elem_reg.literal == ctl.byte_value);
            K_ONE:   hit = 1'b1;
            K_SET:   hit = row[elem_reg.slot[SLOT_W-1:0]];
            default: hit = 1'b0;
        endcase
    end

    assign adv_out  = act_c & live & hit;
    assign clo_out  = act_c & any;
    assign act_next = (act_c & any) | adv_in
                    | (act_c & is_end & (ctl.byte_value == CH_SPACE));

    // advance the active bit on each subject byte
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.init) begin
            act_reg <= FIRST;
        end else if (ctl.step) begin
            act_reg <= act_next;
        end
    end

endmodule

@@ design/slpm_setmem.sv @@
module slpm_setmem #(
    parameter int SETS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [$clog2(SETS > 1 ? SETS : 2)-1:0] slot,
    input  logic                   bit_we,
    input  logic [7:0]             bit_addr,
    input  slpm_pkg::sweep_req_t   sweep,
    input  logic                   rd_en,
    input  logic [7:0]             rd_addr,
    output logic [SETS-1:0]        rd_data,
    output logic                   busy,
    output logic                   done
);
    import slpm_pkg::*;

    logic [SETS-1:0] mem [256];
    logic [7:0]      addr_reg;
    logic [7:0]      hi_reg;
    logic            val_reg;
    logic            busy_reg;

    assign busy = busy_reg;
    assign done = busy_reg && (addr_reg == hi_reg);

    // walk the sweep range one byte a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (sweep.start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (sweep.start) begin
            addr_reg <= sweep.lo;
            hi_reg   <= sweep.hi;
            val_reg  <= sweep.val;
        end else if (busy_reg) begin
            addr_reg <= addr_reg + 8'd1;
        end
    end

    // write one bit of a slot column, read one full row
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[addr_reg][slot] <= val_reg;
        end else if (bit_we) begin
            mem[bit_addr][slot] <= 1'b1;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/sql_like_pattern_matcher.sv @@
// Pattern byte: opening a set stalls while the set memory clears its slot;
// a range x-y with x <= y stalls while the set memory is swept from x to y.
// Subject byte: set-memory row read, then one step of the cell row.
// End words: the status or match word is registered when the end word is accepted.
// Reset (aresetn low, synchronous) clears control state; tables are not swept.
`include "sql_like_pattern_matcher_macros.svh"
module sql_like_pattern_matcher #(
    parameter int MAX_ELEMENTS = 32,
    parameter int MAX_SETS     = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  slpm_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output slpm_pkg::out_word_t  m_data
);
    import slpm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int SET_W  = $clog2(MAX_SETS + 1);
    localparam int SLOT_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int NCELL  = MAX_ELEMENTS + 1;

    logic [7:0]        esc_reg;
    state_t            state_reg, state_next;
    phase_t            ph_reg, ph_next, ph_e;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_e;
    logic [SET_W-1:0]  sets_reg, sets_next, sets_e;
    logic [7:0]        prev_reg, prev_next;
    logic              ra_reg, ra_next;
    logic              neg_reg, neg_next;
    logic              valid_reg, valid_next;
    logic [2:0]        err_reg, err_next;
    kind_t             last_kind_reg, last_kind_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [MAX_SETS-1:0] negset_reg;
    logic              close_we;
    logic [7:0]        byte_reg;
    logic              m_valid_reg;
    out_word_t         m_data_reg;

    logic              acc, out_free;
    logic [7:0]        b;
    logic              add_req, open_req, body_req;
    kind_t             add_kind;
    logic [7:0]        add_lit;
    logic              elem_we;
    elem_t             elem_w;
    logic              bit_we;
    logic [7:0]        bit_addr;
    sweep_req_t        sweep;
    logic              mem_busy, mem_done;
    logic [MAX_SETS-1:0] row_raw, row;
    cell_ctl_t         ctl;
    logic              step;
    logic [2:0]        end_err;
    logic              match_bit;

    logic [NCELL:0]    clo, adv;
    logic [NCELL-1:0]  act_c;
    logic [NCELL-1:0]  end_hit;

    assign b        = s_data.byte_value;
    assign out_free = !m_valid_reg || m_ready;
    assign acc      = s_valid && s_ready;

    // hold the escape byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg <= 8'd0;
        end else if (cfg_wr_en) begin
            esc_reg <= cfg_wr_data;
        end
    end

    // next state of the sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCEPT: begin
                if (acc && sweep.start) begin
                    state_next = ST_SWEEP;
                end else if (acc && s_data.op == OP_SUB_BYTE && valid_reg) begin
                    state_next = ST_MATCH;
                end
            end
            ST_SWEEP: begin
                if (mem_done) begin
                    state_next = ST_ACCEPT;
                end
            end
            ST_MATCH: state_next = ST_ACCEPT;
            default:  state_next = ST_ACCEPT;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready = (state_reg == ST_ACCEPT) && out_free;
        step    = (state_reg == ST_MATCH);
    end

    // compile pattern bytes
    always_comb begin
        ph_e   = (ph_reg == PH_IDLE) ? PH_NORMAL : ph_reg;
        cnt_e  = (ph_reg == PH_IDLE) ? '0 : cnt_reg;
        sets_e = (ph_reg == PH_IDLE) ? '0 : sets_reg;

        ph_next        = ph_reg;
        cnt_next       = cnt_reg;
        sets_next      = sets_reg;
        prev_next      = prev_reg;
        ra_next        = ra_reg;
        neg_next       = neg_reg;
        valid_next     = valid_reg;
        err_next       = err_reg;
        last_kind_next = last_kind_reg;
        slot_next      = slot_reg;
        close_we       = 1'b0;
        add_req        = 1'b0;
        open_req       = 1'b0;
        body_req       = 1'b0;
        add_kind       = K_LIT;
        add_lit        = b;
        elem_we        = 1'b0;
        elem_w         = '{kind: K_LIT, literal: b, slot: '0};
        bit_we         = 1'b0;
        bit_addr       = b;
        sweep          = '{start: 1'b0, lo: 8'd0, hi: 8'hFF, val: 1'b0};
        end_err        = ERR_NONE;

        case (ph_reg)
            PH_NORMAL: end_err = (cnt_reg == '0) ? ERR_EMPTY : ERR_NONE;
            PH_IDLE:   end_err = ERR_EMPTY;
            PH_ESCAPE: end_err = ERR_ESCAPE;
            PH_ERROR:  end_err = err_reg;
            default:   end_err = ERR_BRACKET;
        endcase

        if (acc && s_data.op == OP_PAT_BYTE) begin
            ph_next    = ph_e;
            cnt_next   = cnt_e;
            sets_next  = sets_e;
            valid_next = 1'b0;
            if (ph_reg == PH_IDLE) begin
                err_next = ERR_NONE;
            end
            case (ph_e)
                PH_NORMAL: begin
                    if (esc_reg != 8'd0 && b == esc_reg) begin
                        ph_next = PH_ESCAPE;
                    end else if (b == CH_PERCENT) begin
                        if (cnt_e == '0 || last_kind_reg != K_ANY) begin
                            add_req  = 1'b1;
                            add_kind = K_ANY;
                        end
                    end else if (b == CH_UNDER) begin
                        add_req  = 1'b1;
                        add_kind = K_ONE;
                    end else if (b == CH_LBRACK) begin
                        open_req = 1'b1;
                    end else begin
                        add_req = 1'b1;
                    end
                end
                PH_ESCAPE: begin
                    ph_next = PH_NORMAL;
                    add_req = 1'b1;
                end
                PH_OPEN: begin
                    if (b == CH_CARET && !neg_reg) begin
                        neg_next = 1'b1;
                    end else if (b == CH_RBRACK && neg_reg) begin
                        err_next = ERR_BAD_SET;
                        ph_next  = PH_ERROR;
                    end else if (b == CH_DASH) begin
                        bit_we  = 1'b1;
                        ph_next = PH_LEADDASH;
                    end else begin
                        body_req = 1'b1;
                    end
                end
                PH_LEADDASH: begin
                    if (b == CH_DASH) begin
                        err_next = ERR_BAD_SET;
                        ph_next  = PH_ERROR;
                    end else begin
                        body_req = 1'b1;
                    end
                end
                PH_BODY: body_req = 1'b1;
                PH_RANGE: begin
                    if (b == CH_RBRACK) begin
                        err_next = ERR_BAD_SET;
                        ph_next  = PH_ERROR;
                    end else begin
                        sweep     = '{start: (prev_reg <= b), lo: prev_reg, hi: b, val: 1'b1};
                        prev_next = b;
                        ra_next   = 1'b0;
                        ph_next   = PH_BODY;
                    end
                end
                default: ph_next = ph_e;
            endcase

            // one byte of a set body
            if (body_req) begin
                ph_next = PH_BODY;
                if (b == CH_RBRACK) begin
                    close_we = 1'b1;
                    ph_next  = PH_NORMAL;
                end else if (b != CH_DASH) begin
                    bit_we    = 1'b1;
                    ra_next   = 1'b1;
                    prev_next = b;
                end else if (!ra_reg) begin
                    err_next = ERR_BAD_SET;
                    ph_next  = PH_ERROR;
                end else begin
                    ph_next = PH_RANGE;
                end
            end

            // append an element, or fail on overflow
            if (add_req) begin
                if (cnt_e >= CNT_W'(MAX_ELEMENTS)) begin
                    err_next = ERR_LONG;
                    ph_next  = PH_ERROR;
                end else begin
                    elem_we        = 1'b1;
                    elem_w         = '{kind: add_kind, literal: add_lit, slot: '0};
                    cnt_next       = cnt_e + CNT_W'(1);
                    last_kind_next = add_kind;
                end
            end

            // open a set and clear its slot
            if (open_req) begin
                if (sets_e >= SET_W'(MAX_SETS) || cnt_e >= CNT_W'(MAX_ELEMENTS)) begin
                    err_next = ERR_LONG;
                    ph_next  = PH_ERROR;
                end else begin
                    elem_we        = 1'b1;
                    elem_w         = '{kind: K_SET, literal: 8'd0,
                                       slot: SLOT_FW'(sets_e)};
                    cnt_next       = cnt_e + CNT_W'(1);
                    last_kind_next = K_SET;
                    sets_next      = sets_e + SET_W'(1);
                    slot_next      = SLOT_W'(sets_e);
                    neg_next       = 1'b0;
                    ra_next        = 1'b0;
                    prev_next      = 8'd0;
                    ph_next        = PH_OPEN;
                    sweep          = '{start: 1'b1, lo: 8'd0, hi: 8'hFF, val: 1'b0};
                end
            end
        end else if (acc && s_data.op == OP_PAT_END) begin
            err_next   = end_err;
            valid_next = (end_err == ERR_NONE);
            ph_next    = PH_IDLE;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCEPT;
            ph_reg        <= PH_NORMAL;
            cnt_reg       <= '0;
            sets_reg      <= '0;
            prev_reg      <= 8'd0;
            ra_reg        <= 1'b0;
            neg_reg       <= 1'b0;
            valid_reg     <= 1'b0;
            err_reg       <= ERR_NONE;
            last_kind_reg <= K_LIT;
            slot_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            cnt_reg       <= cnt_next;
            sets_reg      <= sets_next;
            prev_reg      <= prev_next;
            ra_reg        <= ra_next;
            neg_reg       <= neg_next;
            valid_reg     <= valid_next;
            err_reg       <= err_next;
            last_kind_reg <= last_kind_next;
            slot_reg      <= slot_next;
            if (acc && (s_data.op == OP_PAT_END || s_data.op == OP_SUB_END)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // latch negation at set close, hold subject byte, build result word
    always_ff @(posedge aclk) begin
        if (close_we) begin
            negset_reg[slot_reg] <= neg_reg;
        end
        if (acc) begin
            byte_reg <= b;
        end
        if (acc && s_data.op == OP_PAT_END) begin
            m_data_reg <= '{result_kind: 1'b0, matched: 1'b0, error_code: end_err};
        end else if (acc && s_data.op == OP_SUB_END) begin
            m_data_reg <= '{result_kind: 1'b1, matched: valid_reg && match_bit,
                            error_code: valid_reg ? ERR_NONE : ERR_NO_PAT};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    slpm_setmem #(.SETS(MAX_SETS)) u_setmem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .slot     (slot_reg),
        .bit_we   (bit_we),
        .bit_addr (bit_addr),
        .sweep    (sweep),
        .rd_en    (acc && s_data.op == OP_SUB_BYTE),
        .rd_addr  (b),
        .rd_data  (row_raw),
        .busy     (mem_busy),
        .done     (mem_done)
    );

    // negated sets flip every byte but zero
    assign row = row_raw ^ (negset_reg & {MAX_SETS{byte_reg != 8'd0}});

    assign ctl = '{init: acc && (s_data.op == OP_PAT_END || s_data.op == OP_SUB_END),
                   step: step, byte_value: byte_reg};

    assign clo[0] = 1'b0;
    assign adv[0] = 1'b0;

    // row of element cells, position MAX_ELEMENTS is the end slot at most
    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        slpm_cell #(.SETS(MAX_SETS), .FIRST(i == 0)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .we      (elem_we && cnt_e == CNT_W'(i)),
            .wr_elem (elem_w),
            .live    (CNT_W'(i) < cnt_reg),
            .is_end  (CNT_W'(i) == cnt_reg),
            .row     (row),
            .clo_in  (clo[i]),
            .adv_in  (adv[i]),
            .clo_out (clo[i+1]),
            .adv_out (adv[i+1]),
            .act_c   (act_c[i])
        );
        assign end_hit[i] = act_c[i] && (CNT_W'(i) == cnt_reg);
    end

    assign match_bit = |end_hit;

    `SLPM_ASSERT(a_busy_stalls, aclk, aresetn, mem_busy |-> !s_ready)
    `SLPM_ASSERT(a_cnt_bound, aclk, aresetn,
        (cnt_reg <= CNT_W'(MAX_ELEMENTS)) && (sets_reg <= SET_W'(MAX_SETS)))
    `SLPM_ASSERT(a_end_result, aclk, aresetn,
        (acc && (s_data.op == OP_PAT_END || s_data.op == OP_SUB_END)) |=> m_valid_reg)
    `SLPM_ASSERT(a_match_one_cycle, aclk, aresetn, (state_reg == ST_MATCH) |=> s_ready || !out_free)
    `SLPM_NEVER(a_chain_end, aclk, aresetn, adv[NCELL] || clo[NCELL])

endmodule

@@ dv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import slpm_pkg::*;

    localparam int ELEMS      = 32;
    localparam int SETS       = 8;
    localparam int LIMIT      = 1500000;
    localparam int DRAIN      = 300;
    localparam int HOLD_LEN   = 3000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_data;

    sql_like_pattern_matcher #(.MAX_ELEMENTS(ELEMS), .MAX_SETS(SETS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #2 aclk = ~aclk;

    // words waiting to be driven and status/match words still owed by the block
    in_word_t  pending_words[$];
    out_word_t owed_status[$];
    int        words_sent = 0;
    int        words_taken = 0;
    int        errors = 0;
    int        cycles = 0;
    int        s_idle_pct = 0;
    int        m_idle_pct = 0;
    bit        hold_go = 1'b0;
    bit        hold = 1'b0;
    int        n_compiles = 0;
    int        n_hits = 0;
    int        n_subjects = 0;

    // ---------------- matcher shadow state ----------------
    logic [7:0]  esc_byte = 8'd0;
    phase_t      ph = PH_NORMAL;
    kind_t       tbl_kind[ELEMS];
    logic [7:0]  tbl_lit[ELEMS];
    int          tbl_slot[ELEMS];
    bit          set_map[SETS][256];
    int          n_elems = 0;
    int          n_sets = 0;
    logic [7:0]  last_set_byte = 8'd0;
    bit          range_ok = 1'b0;
    bit          negate = 1'b0;
    bit          pat_ok = 1'b0;
    logic [2:0]  pat_err = ERR_NONE;
    logic [32:0] live = 33'd1;

    function automatic void compile_fail(logic [2:0] code);
        pat_err = code;
        ph = PH_ERROR;
    endfunction

    function automatic bit table_push(kind_t k, logic [7:0] lit, int slot);
        if (n_elems >= ELEMS) begin
            compile_fail(ERR_LONG);
            return 1'b0;
        end
        tbl_kind[n_elems] = k;
        tbl_lit[n_elems]  = lit;
        tbl_slot[n_elems] = slot;
        n_elems++;
        return 1'b1;
    endfunction

    function automatic int open_slot();
        if (n_elems == 0) return 0;
        return tbl_slot[n_elems-1] % SETS;
    endfunction

    function automatic void set_open();
        int slot;
        slot = n_sets;
        if (slot >= SETS) begin
            compile_fail(ERR_LONG);
            return;
        end
        if (!table_push(K_SET, 8'd0, slot)) return;
        for (int v = 0; v < 256; v++) set_map[slot][v] = 1'b0;
        n_sets++;
        negate = 1'b0;
        range_ok = 1'b0;
        last_set_byte = 8'd0;
        ph = PH_OPEN;
    endfunction

    // close: negation flips bytes 1..255, byte zero stays
    function automatic void set_member(logic [7:0] b);
        int slot;
        slot = open_slot();
        if (b == CH_RBRACK) begin
            if (negate)
                for (int v = 1; v < 256; v++) set_map[slot][v] = !set_map[slot][v];
            ph = PH_NORMAL;
        end else if (b != CH_DASH) begin
            set_map[slot][b] = 1'b1;
            range_ok = 1'b1;
            last_set_byte = b;
        end else if (!range_ok) begin
            compile_fail(ERR_BAD_SET);
        end else begin
            ph = PH_RANGE;
        end
    endfunction

    function automatic void compile_byte(logic [7:0] b);
        if (ph == PH_IDLE) begin
            n_elems = 0;
            n_sets = 0;
            pat_err = ERR_NONE;
            ph = PH_NORMAL;
        end
        pat_ok = 1'b0;
        case (ph)
            PH_NORMAL: begin
                if (esc_byte != 8'd0 && b == esc_byte) ph = PH_ESCAPE;
                else if (b == CH_PERCENT) begin
                    if (n_elems == 0 || tbl_kind[n_elems-1] != K_ANY)
                        void'(table_push(K_ANY, 8'd0, 0));
                end else if (b == CH_UNDER) void'(table_push(K_ONE, 8'd0, 0));
                else if (b == CH_LBRACK) set_open();
                else void'(table_push(K_LIT, b, 0));
            end
            PH_ESCAPE: begin
                ph = PH_NORMAL;
                void'(table_push(K_LIT, b, 0));
            end
            PH_OPEN: begin
                if (b == CH_CARET && !negate) negate = 1'b1;
                else if (b == CH_RBRACK && negate) compile_fail(ERR_BAD_SET);
                else if (b == CH_DASH) begin
                    set_map[open_slot()][CH_DASH] = 1'b1;
                    ph = PH_LEADDASH;
                end else begin
                    ph = PH_BODY;
                    set_member(b);
                end
            end
            PH_LEADDASH: begin
                if (b == CH_DASH) compile_fail(ERR_BAD_SET);
                else begin
                    ph = PH_BODY;
                    set_member(b);
                end
            end
            PH_BODY: set_member(b);
            PH_RANGE: begin
                if (b == CH_RBRACK) compile_fail(ERR_BAD_SET);
                else begin
                    for (int v = last_set_byte; v <= b; v++) set_map[open_slot()][v] = 1'b1;
                    last_set_byte = b;
                    range_ok = 1'b0;
                    ph = PH_BODY;
                end
            end
            default: ;
        endcase
    endfunction

    // let each active % also activate the position after it
    function automatic logic [32:0] spread_any(logic [32:0] a);
        for (int i = 0; i < n_elems; i++)
            if (a[i] && tbl_kind[i] == K_ANY) a[i+1] = 1'b1;
        return a;
    endfunction

    function automatic void step_subject(logic [7:0] b);
        logic [32:0] a, n;
        a = spread_any(live);
        n = '0;
        for (int i = 0; i < n_elems; i++) begin
            if (a[i]) begin
                case (tbl_kind[i])
                    K_ANY: n[i] = 1'b1;
                    K_ONE: n[i+1] = 1'b1;
                    K_LIT: if (tbl_lit[i] == b) n[i+1] = 1'b1;
                    default: if (tbl_slot[i] < SETS && set_map[tbl_slot[i]][b]) n[i+1] = 1'b1;
                endcase
            end
        end
        if (a[n_elems] && b == CH_SPACE) n[n_elems] = 1'b1;
        live = n;
    endfunction

    function automatic void predict_word(in_word_t w);
        out_word_t r;
        logic [2:0] e;
        logic [32:0] closed;
        r = '0;
        case (op_t'(w.op))
            OP_PAT_BYTE: compile_byte(w.byte_value);
            OP_SUB_BYTE: if (pat_ok) step_subject(w.byte_value);
            OP_PAT_END: begin
                case (ph)
                    PH_NORMAL: e = (n_elems == 0) ? ERR_EMPTY : ERR_NONE;
                    PH_IDLE:   e = ERR_EMPTY;
                    PH_ESCAPE: e = ERR_ESCAPE;
                    PH_ERROR:  e = pat_err;
                    default:   e = ERR_BRACKET;
                endcase
                pat_err = e;
                pat_ok = (e == ERR_NONE);
                ph = PH_IDLE;
                live = 33'd1;
                r.error_code = e;
                n_compiles++;
                owed_status.push_back(r);
            end
            default: begin
                r.result_kind = 1'b1;
                if (!pat_ok) r.error_code = ERR_NO_PAT;
                else begin
                    closed = spread_any(live);
                    r.matched = closed[n_elems];
                    live = 33'd1;
                end
                n_subjects++;
                if (r.matched) n_hits++;
                owed_status.push_back(r);
            end
        endcase
    endfunction

    // ---------------- checking ----------------
    task automatic report(string what, int got, int want);
        $display("ERROR: %s got %0d want %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // monitor: predict on accepted input words, compare result words
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_word(s_data);
                words_taken <= words_taken + 1;
            end
            if (m_valid && m_ready) begin
                if (owed_status.size() == 0) report("unexpected result word", m_data, 0);
                else begin
                    want = owed_status.pop_front();
                    if (m_data.result_kind !== want.result_kind)
                        report("result_kind", m_data.result_kind, want.result_kind);
                    if (m_data.matched !== want.matched)
                        report("matched", m_data.matched, want.matched);
                    if (m_data.error_code !== want.error_code)
                        report("error_code", m_data.error_code, want.error_code);
                end
            end
        end
    end

    // driver: advance to the next word once the current one is taken
    always @(negedge aclk) begin
        if (aresetn && words_taken == words_sent) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= s_idle_pct) begin
                s_data <= pending_words.pop_front();
                s_valid <= 1'b1;
                words_sent <= words_sent + 1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver with random stalls
    always @(negedge aclk) begin
        m_ready <= aresetn && !hold && ($urandom_range(99) >= m_idle_pct);
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (hold_go);
        @(negedge aclk);
        hold = 1'b1;
        repeat (HOLD_LEN) @(negedge aclk);
        hold = 1'b0;
    end

    // ---------------- stimulus ----------------
    task automatic put(op_t op, logic [7:0] b);
        in_word_t w;
        w.op = op;
        w.byte_value = b;
        pending_words.push_back(w);
    endtask

    task automatic put_pattern(string s);
        for (int i = 0; i < s.len(); i++) put(OP_PAT_BYTE, s[i]);
        put(OP_PAT_END, 8'($urandom_range(255)));
    endtask

    task automatic put_subject(string s);
        for (int i = 0; i < s.len(); i++) put(OP_SUB_BYTE, s[i]);
        put(OP_SUB_END, 8'($urandom_range(255)));
    endtask

    task automatic write_escape(logic [7:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        esc_byte = v;
    endtask

    task automatic settle();
        while (pending_words.size() != 0 || words_taken != words_sent || s_valid
               || owed_status.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic gen_set();
        int k;
        put(OP_PAT_BYTE, CH_LBRACK);
        if ($urandom_range(3) == 0) put(OP_PAT_BYTE, CH_CARET);
        if ($urandom_range(4) == 0) put(OP_PAT_BYTE, CH_DASH);
        k = $urandom_range(3);
        repeat (k) begin
            if ($urandom_range(2) == 0) begin
                if ($urandom_range(19) == 0) begin
                    put(OP_PAT_BYTE, 8'd1);
                    put(OP_PAT_BYTE, CH_DASH);
                    put(OP_PAT_BYTE, 8'd255);
                end else begin
                    put(OP_PAT_BYTE, 8'($urandom_range(97, 100)));
                    put(OP_PAT_BYTE, CH_DASH);
                    put(OP_PAT_BYTE, 8'($urandom_range(96, 101)));
                end
            end else begin
                put(OP_PAT_BYTE, 8'($urandom_range(97, 100)));
            end
        end
        put(OP_PAT_BYTE, CH_RBRACK);
    endtask

    task automatic gen_pattern();
        int r, n;
        r = $urandom_range(99);
        if (r < 80) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                case ($urandom_range(5))
                    0: put(OP_PAT_BYTE, CH_PERCENT);
                    1: put(OP_PAT_BYTE, CH_UNDER);
                    2: gen_set();
                    3: if (esc_byte != 8'd0) begin
                        put(OP_PAT_BYTE, esc_byte);
                        put(OP_PAT_BYTE, 8'($urandom_range(255)));
                    end else put(OP_PAT_BYTE, 8'($urandom_range(255)));
                    default: put(OP_PAT_BYTE, ($urandom_range(7) == 0) ? CH_SPACE
                                              : 8'($urandom_range(97, 99)));
                endcase
            end
            // broken tail: syntax bytes dropped in at random
            if (r >= 68) begin
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(4))
                        0: put(OP_PAT_BYTE, CH_LBRACK);
                        1: put(OP_PAT_BYTE, CH_DASH);
                        2: put(OP_PAT_BYTE, CH_CARET);
                        3: put(OP_PAT_BYTE, CH_RBRACK);
                        default: put(OP_PAT_BYTE, esc_byte);
                    endcase
                end
            end
        end else if (r < 86) begin
            repeat ($urandom_range(31, 34)) put(OP_PAT_BYTE, 8'($urandom_range(97, 98)));
        end else if (r < 90) begin
            repeat ($urandom_range(8, 9)) begin
                put(OP_PAT_BYTE, CH_LBRACK);
                put(OP_PAT_BYTE, 8'd97);
                put(OP_PAT_BYTE, CH_RBRACK);
            end
        end else if (r < 95) begin
            repeat ($urandom_range(1, 5)) put(OP_PAT_BYTE, 8'($urandom_range(255)));
        end
        put(OP_PAT_END, 8'($urandom_range(255)));
    endtask

    task automatic gen_subjects();
        repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(9))
                    0: put(OP_SUB_BYTE, 8'($urandom_range(255)));
                    1: put(OP_SUB_BYTE, CH_SPACE);
                    2: put(OP_SUB_BYTE, CH_DASH);
                    default: put(OP_SUB_BYTE, 8'($urandom_range(97, 100)));
                endcase
            end
            put(OP_SUB_END, 8'($urandom_range(255)));
        end
    endtask

    task automatic gen_phase(int target);
        while (pending_words.size() < target) begin
            if ($urandom_range(19) == 0)
                put(op_t'(2'($urandom_range(3))), 8'($urandom_range(255)));
            else begin
                gen_pattern();
                gen_subjects();
            end
        end
    endtask

    task automatic set_idling(int mode);
        case (mode % 3)
            0: begin s_idle_pct = 9;  m_idle_pct = 56; end
            1: begin s_idle_pct = 56; m_idle_pct = 9;  end
            default: begin s_idle_pct = 0; m_idle_pct = 0; end
        endcase
    endtask

    logic [7:0] escapes[6] = '{8'h5C, 8'hFF, 8'h01, 8'h25, 8'hAA, 8'h00};

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_escape(8'h00);
        set_idling(0);

        // directed: no pattern yet, empty pattern, wildcards, sets, set errors
        put_subject("x");
        put(OP_PAT_END, 8'h00);
        put_pattern("a%%_");
        put_subject("ab");
        put_subject("a");
        put_pattern("[^-a]");
        put_subject({8'd0});
        put_pattern("[a-]");
        put_pattern("[--");
        put_pattern("[^]");
        put_pattern("[z-a");
        put(OP_PAT_END, 8'hFF);
        put_pattern({8'hFF, 8'h00});
        put_subject({8'hFF, 8'h00, " "});
        settle();

        write_escape(8'h5C);
        put_pattern("\\%");
        put_subject("% ");
        put_pattern("a\\");
        settle();

        for (int p = 0; p < 6; p++) begin
            write_escape(escapes[p]);
            set_idling(p);
            if (p == 2) hold_go = 1'b1;
            gen_phase(120);
            settle();
        end

        $display("run covered %0d input words: %0d pattern ends, %0d subjects, %0d matches",
                 words_taken, n_compiles, n_subjects, n_hits);
        $display("escape settings, idle mixes and a long receiver hold-off all exercised");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
